// ===== hw/rtl/slpi_pkg.sv =====
// ----------------------------------------------------------------------------
// slpi_pkg
// Shared types and codes for the positional insert list core: action codes,
// result status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package slpi_pkg;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_REJECT  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_READ,
        S_RESULT
    } state_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_value;
        logic [7:0]         current_length;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slpi_mem.sv =====
// ----------------------------------------------------------------------------
// slpi_mem
// Element store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slpi_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [31:0]            rdata
);

    logic [31:0] mem_array [DEPTH];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/slpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpi_ctrl
// Sequencer for load, insert and read. Holds the list length and the load
// reject flag, drives the element store and moves elements one per cycle
// for an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module slpi_ctrl
    import slpi_pkg::*;
#(
    parameter int CAPACITY = 128,
    parameter int ADDR_W   = 7,
    parameter int LEN_W    = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // item in
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_action,
    input  wire logic              in_first,
    input  wire logic [7:0]        in_count,
    input  wire logic [7:0]        in_pos,
    input  wire logic [31:0]       in_value,
    // result out
    output logic                   res_valid,
    input  wire logic              res_ready,
    output res_t                   res,
    // element store
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic [31:0]            mem_wdata,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  wire logic [31:0]       mem_rdata
);

    localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                rej_reg, rej_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   pm1_reg, pm1_next;
    logic [31:0]         val_reg, val_next;
    status_t             stat_reg, stat_next;
    logic [31:0]         rd_reg, rd_next;

    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    pos_m1;
    logic                full;
    logic [ADDR_W-1:0]   idx_m1;
    logic                accept;

    assign len_ext = CMP_W'(len_reg);
    assign pos_ext = CMP_W'(in_pos);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign full    = (len_ext >= CAP_C);
    assign idx_m1  = idx_reg - ADDR_W'(1);
    assign accept  = in_valid && in_ready;

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            rej_reg   <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pm1_reg  <= pm1_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
        rd_reg   <= rd_next;
    end

    // Next state, store access and result
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        rej_next   = rej_reg;
        idx_next   = idx_reg;
        pm1_next   = pm1_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        rd_next    = rd_reg;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(len_reg);
        mem_wdata  = in_value;
        mem_raddr  = ADDR_W'(pos_m1);
        in_ready   = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_RESULT);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_next    = '0;
                    state_next = S_RESULT;
                    unique case (in_action)
                        ACT_LOAD:
                        begin
                            if (in_first && (CMP_W'(in_count) > CAP_C))
                            begin
                                rej_next  = 1'b1;
                                stat_next = STAT_REJECT;
                            end
                            else if (in_first)
                            begin
                                // start a new list; append unless count is zero
                                rej_next  = 1'b0;
                                stat_next = STAT_OK;
                                if (in_count == 8'd0)
                                begin
                                    len_next = '0;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    len_next  = LEN_W'(1);
                                end
                            end
                            else if (rej_reg || full)
                            begin
                                stat_next = STAT_REJECT;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                stat_next = STAT_OK;
                                len_next  = len_reg + LEN_W'(1);
                            end
                        end
                        ACT_INSERT:
                        begin
                            if ((pos_ext == '0) || (pos_ext > len_ext + CMP_W'(1)))
                            begin
                                stat_next = STAT_BAD_POS;
                            end
                            else if (full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (pos_m1 == len_ext)
                            begin
                                // append at the tail, nothing to move
                                mem_we    = 1'b1;
                                stat_next = STAT_OK;
                                len_next  = len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                // start moving from the tail down
                                pm1_next   = ADDR_W'(pos_m1);
                                val_next   = in_value;
                                idx_next   = ADDR_W'(len_reg);
                                mem_raddr  = ADDR_W'(len_reg) - ADDR_W'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_READ:
                        begin
                            if ((pos_ext == '0) || (pos_ext > len_ext))
                            begin
                                stat_next = STAT_BAD_POS;
                            end
                            else
                            begin
                                mem_raddr  = ADDR_W'(pos_m1);
                                stat_next  = STAT_OK;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_BAD_POS;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // move element idx-1 up to idx, fetch the next one down
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_m1 - ADDR_W'(1);
                idx_next  = idx_m1;
                if (idx_m1 == pm1_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pm1_reg;
                mem_wdata  = val_reg;
                len_next   = len_reg + LEN_W'(1);
                stat_next  = STAT_OK;
                state_next = S_RESULT;
            end
            S_READ:
            begin
                rd_next    = mem_rdata;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status         = stat_reg;
    assign res.read_value     = rd_reg;
    assign res.current_length = 8'(len_reg);

    // Length never passes capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_ext <= CAP_C)
        else $error("list length above capacity");

    // Moves only go on above the insert point
    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_reg > pm1_reg))
        else $error("shift index at or below insert point");

    // Placing the new value grows the list by one
    a_put_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (len_reg == $past(len_reg) + LEN_W'(1)))
        else $error("insert did not grow the list");

    // No store write while a read or a result is pending
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) || (state_reg == S_RESULT)) |-> !mem_we)
        else $error("store written outside of load or insert");

endmodule

`default_nettype wire

// ===== hw/rtl/sequential_list_positional_insert_core.sv =====
// ----------------------------------------------------------------------------
// sequential_list_positional_insert_core
// Array list of signed 32-bit elements with load, positional insert and read.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                    tuser
//  s_axis    in   [7:0] list_count [15:8] position         [1:0] action
//                 [47:16] value                            [2] first
//  m_axis    out  [31:0] read_value [39:32] current_length [1:0] status
//
//  Load, tail insert and every error go from accept straight to the result.
//  A good read passes through the registered store read before its result.
//  Insert at position p into a list of n moves the n - p + 1 elements at and
//  above p one per cycle through the store's port pair, then places the value.
//  Reset clears length and reject flag at once; the store needs no clearing.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_positional_insert_core
    import slpi_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // list_count, position, value
    input  wire logic [2:0]  s_axis_tuser,  // action, first
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // read_value, current_length
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W  = $clog2(CAPACITY + 1);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [31:0]       mem_rdata;

    logic              out_valid_reg;
    res_t              out_res_reg;

    slpi_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .LEN_W    (LEN_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[1:0]),
        .in_first  (s_axis_tuser[2]),
        .in_count  (s_axis_tdata[7:0]),
        .in_pos    (s_axis_tdata[15:8]),
        .in_value  (s_axis_tdata[47:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    slpi_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.current_length, out_res_reg.read_value};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire
